@@ sv/pmrf_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the pump Modbus request framer.
package pmrf_pkg;

  // Pump command codes
  typedef enum logic [2:0] {
    CMD_LAUNCH    = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_SET_SPEED = 3'd2,
    CMD_FORWARD   = 3'd3,
    CMD_REVERSE   = 3'd4,
    CMD_SET_ADDR  = 3'd5,
    CMD_READ_SPD  = 3'd6,
    CMD_READ_MAX  = 3'd7
  } cmd_e;

  // Modbus function codes
  localparam logic [7:0] FN_WRITE = 8'd6;
  localparam logic [7:0] FN_READ  = 8'd3;

  // Pump register numbers (high byte is always zero)
  localparam logic [2:0] REG_RUN   = 3'd0;
  localparam logic [2:0] REG_DIR   = 3'd1;
  localparam logic [2:0] REG_SPEED = 3'd2;
  localparam logic [2:0] REG_ADDR  = 3'd3;
  localparam logic [2:0] REG_MAX   = 3'd6;

  localparam logic [7:0] BCAST_ADDR = 8'd0;

  // CRC-16/Modbus
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Byte positions within a frame
  localparam logic [2:0] BYTE_SLAVE  = 3'd0;
  localparam logic [2:0] BYTE_FN     = 3'd1;
  localparam logic [2:0] BYTE_REG_HI = 3'd2;
  localparam logic [2:0] BYTE_REG_LO = 3'd3;
  localparam logic [2:0] BYTE_VAL_HI = 3'd4;
  localparam logic [2:0] BYTE_VAL_LO = 3'd5;
  localparam logic [2:0] BYTE_CRC_LO = 3'd6;
  localparam logic [2:0] BYTE_CRC_HI = 3'd7;

  // Queue depth in frames
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // One frame to be sent
  typedef struct packed {
    logic [7:0]  slave;
    logic        is_read;
    logic [2:0]  reg_lo;
    logic [15:0] value;
    logic        last;
  } frame_desc_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ sv/pump_modbus_request_framer.sv @@
// Top level of the pump Modbus RTU request framer.
//
//  channel  direction  handshake               words
//  in       input      in_valid_i / in_stall_o   command_i, pump_address_i, value_word_i
//  out      output     out_valid_o / out_stall_i tx_byte_o, frame_end_o, run_end_o
//
// One output word (byte) per cycle while a frame is queued and out_stall_i is low, set by
// the single byte serialiser in the back end: 8 bytes per command, 24 for forward and reverse.
// A command's first byte passes the front's command registers, the frame queue and the back's output byte register.
// Reset (rst_ni low, asynchronous) empties the frame queue and drops any word in flight.
// Output stalls back up through the frame queue to the front, which then stalls the input.
module pump_modbus_request_framer import pmrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  pump_address_i,
  input  logic [15:0] value_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        frame_end_o,
  output logic        run_end_o
);

  q_status_t   q_status;
  logic        push, pop;
  frame_desc_t push_desc, head;

  // Front: latches a command and pushes one descriptor per frame
  pmrf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .pump_address_i (pump_address_i),
    .value_word_i   (value_word_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .desc_o         (push_desc)
  );

  // Frame queue decouples command expansion from byte output
  pmrf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Back: byte serialiser with running CRC and registered output word
  pmrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .frame_end_o (frame_end_o),
    .run_end_o   (run_end_o)
  );

endmodule

@@ sv/pmrf_front.sv @@
// Front end: accepts pump commands and expands them into frame descriptors.
module pmrf_front import pmrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  pump_address_i,
  input  logic [15:0] value_word_i,
  input  q_status_t   q_status_i,
  output logic        push_o,
  output frame_desc_t desc_o
);

  logic        busy_q, busy_d;
  logic [1:0]  idx_q, idx_d;
  cmd_e        cmd_q;
  logic [7:0]  addr_q;
  logic [15:0] val_q;
  logic        accept;

  always_comb begin
    desc_o         = '0;
    desc_o.slave   = addr_q;
    desc_o.is_read = 1'b0;
    desc_o.last    = 1'b1;
    unique case (cmd_q) inside
      CMD_LAUNCH: begin
        desc_o.reg_lo = REG_RUN;
        desc_o.value  = 16'd1;
      end
      CMD_STOP: begin
        desc_o.reg_lo = REG_RUN;
        desc_o.value  = 16'd0;
      end
      CMD_SET_SPEED: begin
        desc_o.reg_lo = REG_SPEED;
        desc_o.value  = val_q;
      end
      CMD_FORWARD, CMD_REVERSE: begin
        // stop, direction, launch
        desc_o.last = (idx_q == 2'd2);
        if (idx_q == 2'd0) begin
          desc_o.reg_lo = REG_RUN;
          desc_o.value  = 16'd0;
        end else if (idx_q == 2'd1) begin
          desc_o.reg_lo = REG_DIR;
          desc_o.value  = {15'd0, cmd_q == CMD_FORWARD};
        end else begin
          desc_o.reg_lo = REG_RUN;
          desc_o.value  = 16'd1;
        end
      end
      CMD_SET_ADDR: begin
        desc_o.slave  = BCAST_ADDR;
        desc_o.reg_lo = REG_ADDR;
        desc_o.value  = {8'd0, val_q[7:0]};
      end
      CMD_READ_SPD: begin
        desc_o.is_read = 1'b1;
        desc_o.reg_lo  = REG_SPEED;
        desc_o.value   = 16'd1;
      end
      default: begin
        desc_o.is_read = 1'b1;
        desc_o.reg_lo  = REG_MAX;
        desc_o.value   = 16'd1;
      end
    endcase
  end

  assign push_o     = busy_q && !q_status_i.full;
  assign in_stall_o = busy_q && !(push_o && desc_o.last);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (accept) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end else if (push_o && desc_o.last) begin
      busy_d = 1'b0;
    end else if (push_o) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(command_i);
      addr_q <= pump_address_i;
      val_q  <= value_word_i;
    end
  end

endmodule

@@ sv/pmrf_queue.sv @@
// Short register queue of frame descriptors between front and back.
module pmrf_queue import pmrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  frame_desc_t push_desc_i,
  input  logic        pop_i,
  output frame_desc_t head_o,
  output q_status_t   status_o
);

  frame_desc_t         mem_q [QDepth];
  logic [QPtrW-1:0]    wr_q, rd_q;
  logic [QPtrW:0]      cnt_q;
  logic                do_push, do_pop;

  assign status_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPtrW'(1);
      if (do_pop)  rd_q <= rd_q + QPtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_desc_i;
  end

endmodule

@@ sv/pmrf_back.sv @@
// Back end: serialises frame descriptors into bytes with running CRC-16.
module pmrf_back import pmrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  frame_desc_t head_i,
  input  q_status_t   q_status_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        frame_end_o,
  output logic        run_end_o
);

  logic [2:0]  cnt_q;
  logic [15:0] crc_q, crc_base;
  logic        ov_q;
  logic [7:0]  byte_q, next_byte;
  logic        fe_q, re_q;
  logic        advance;

  assign advance  = !q_status_i.empty && (!ov_q || !out_stall_i);
  assign pop_o    = advance && (cnt_q == BYTE_CRC_HI);
  assign crc_base = (cnt_q == BYTE_SLAVE) ? CRC_INIT : crc_q;

  always_comb begin
    unique case (cnt_q)
      BYTE_SLAVE:  next_byte = head_i.slave;
      BYTE_FN:     next_byte = head_i.is_read ? FN_READ : FN_WRITE;
      BYTE_REG_HI: next_byte = 8'h00;
      BYTE_REG_LO: next_byte = {5'd0, head_i.reg_lo};
      BYTE_VAL_HI: next_byte = head_i.value[15:8];
      BYTE_VAL_LO: next_byte = head_i.value[7:0];
      BYTE_CRC_LO: next_byte = crc_q[7:0];
      default:     next_byte = crc_q[15:8];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= BYTE_SLAVE;
      ov_q  <= 1'b0;
    end else if (advance) begin
      cnt_q <= cnt_q + 3'd1;
      ov_q  <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= next_byte;
      fe_q   <= (cnt_q == BYTE_CRC_HI);
      re_q   <= (cnt_q == BYTE_CRC_HI) && head_i.last;
      if (cnt_q < BYTE_CRC_LO) crc_q <= crc_byte(crc_base, next_byte);
    end
  end

  assign out_valid_o = ov_q;
  assign tx_byte_o   = byte_q;
  assign frame_end_o = fe_q;
  assign run_end_o   = re_q;

endmodule
